### rtl/bdb_pkg.sv
// Shared constants for the B-spline de Boor evaluator.
`default_nettype none
package bdb_pkg;
    localparam int COORD_W = 32;   // signed Q16.16 coordinate
    localparam int U_W     = 24;   // unsigned Q8.16 parameter
    localparam int FRAC_W  = 16;   // fraction bits of both formats

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [2:0] REG_DEGREE       = 3'd0;
    localparam logic [2:0] REG_POINT_COUNT  = 3'd1;
    localparam logic [2:0] REG_CLAMP_START  = 3'd2;
    localparam logic [2:0] REG_CLAMP_END    = 3'd3;
    localparam logic [2:0] REG_CLOSED_CURVE = 3'd4;
endpackage
`default_nettype wire

### rtl/bdb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### rtl/bdb_blend.sv
// One de Boor blend step on one coordinate: weighted sum, rounded division, saturation.
`default_nettype none
module bdb_blend #(
    parameter int WW = 25,
    parameter int DW = 3
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic signed [31:0]         p0,
    input  wire logic signed [31:0]         p1,
    input  wire logic signed [WW-1:0]       wa,
    input  wire logic signed [WW-1:0]       wb,
    input  wire logic        [DW-1:0]       d,
    output logic                            done,
    output logic             [31:0]         result
);
    import bdb_pkg::*;

    localparam int PRW      = WW + COORD_W;
    localparam int SW       = PRW + 1;
    localparam int MQW      = SW + 1 - FRAC_W;
    localparam int DIV_STEP = 8;
    localparam int DIV_CYC  = COORD_W / DIV_STEP;
    localparam int DCW      = $clog2(DIV_CYC);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_MA   = 7'b0000010,
        B_MB   = 7'b0000100,
        B_SUM  = 7'b0001000,
        B_CHK  = 7'b0010000,
        B_DIV  = 7'b0100000,
        B_OUT  = 7'b1000000
    } blend_state_t;

    blend_state_t state_reg, state_next;

    logic signed [31:0]     p0_reg, p1_reg;
    logic signed [WW-1:0]   wa_reg, wb_reg;
    logic        [DW-1:0]   d_reg;
    logic signed [PRW-1:0]  prod_a_reg, prod_b_reg;
    logic                   neg_reg, sat_reg;
    logic        [MQW-1:0]  mq_reg;
    logic        [DW-1:0]   rem_reg;
    logic        [31:0]     dq_reg, q_reg;
    logic        [DCW-1:0]  cnt_reg;
    logic                   done_reg;
    logic        [31:0]     result_reg;

    logic signed [SW-1:0]   num;
    logic        [SW-1:0]   mag;
    logic        [SW:0]     rnd;
    logic        [MQW-1:0]  lim_pos, lim_neg;
    logic        [DW-1:0]   rem_n;
    logic        [31:0]     dq_n, q_n;
    logic        [DW:0]     trial;

    always_comb begin
        num = {prod_a_reg[PRW-1], prod_a_reg} + {prod_b_reg[PRW-1], prod_b_reg};
        mag = num[SW-1] ? (~num + 1'b1) : num;
        // Adding half the divisor before the floor gives round half away from zero.
        rnd = {1'b0, mag} + ((SW+1)'(d_reg) << (FRAC_W - 1));
        lim_pos = MQW'(d_reg) << (COORD_W - 1);
        lim_neg = lim_pos + MQW'(d_reg);
    end

    // Eight restoring-division steps per cycle on a narrow remainder.
    always_comb begin
        rem_n = rem_reg;
        dq_n  = dq_reg;
        q_n   = q_reg;
        trial = '0;
        for (int s = 0; s < DIV_STEP; s++) begin
            trial = {rem_n, dq_n[31]};
            if (trial >= {1'b0, d_reg}) begin
                rem_n = DW'(trial - {1'b0, d_reg});
                q_n   = {q_n[30:0], 1'b1};
            end else begin
                rem_n = DW'(trial);
                q_n   = {q_n[30:0], 1'b0};
            end
            dq_n = {dq_n[30:0], 1'b0};
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (start) state_next = B_MA;
            B_MA:   state_next = B_MB;
            B_MB:   state_next = B_SUM;
            B_SUM:  state_next = B_CHK;
            B_CHK:  state_next = B_DIV;
            B_DIV:  if (cnt_reg == DCW'(DIV_CYC - 1)) state_next = B_OUT;
            B_OUT:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == B_OUT);
            if (state_reg == B_CHK) begin
                cnt_reg <= '0;
            end else if (state_reg == B_DIV) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                p0_reg <= p0;
                p1_reg <= p1;
                wa_reg <= wa;
                wb_reg <= wb;
                d_reg  <= d;
            end
            B_MA:  prod_a_reg <= wa_reg * p0_reg;
            B_MB:  prod_b_reg <= wb_reg * p1_reg;
            B_SUM: begin
                neg_reg <= num[SW-1];
                mq_reg  <= rnd[SW:FRAC_W];
            end
            B_CHK: begin
                sat_reg <= neg_reg ? (mq_reg >= lim_neg) : (mq_reg >= lim_pos);
                rem_reg <= DW'(mq_reg >> COORD_W);
                dq_reg  <= mq_reg[31:0];
                q_reg   <= '0;
            end
            B_DIV: begin
                rem_reg <= rem_n;
                dq_reg  <= dq_n;
                q_reg   <= q_n;
            end
            B_OUT: begin
                if (sat_reg) begin
                    result_reg <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    result_reg <= neg_reg ? (~q_reg + 1'b1) : q_reg;
                end
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

### rtl/bspline_de_boor_evaluator.sv
// Top level of the B-spline evaluator: point store, span search and de Boor sequencer.
//
// Usage: input beats on s_* carry either a control point load (s_tuser = 0) or an
// evaluate request (s_tuser = 1) with parameter u. A load writes the point store in
// the beat's cycle and gives no result. An evaluate gives one m_* beat with the
// curve point and a status flag (1 when degree is not below the point count).
// Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata; the user
// must do so only while the block is idle, as the block itself does not enforce it.
// The span search tests one knot per cycle, and each blend step runs its three
// coordinates one after another through a single multiply/round/divide unit.
// A degree error skips the span search and the blend steps.
// The input side takes no new beat until the current evaluate has finished.
// The result sits in an output register; a stalled receiver that has not taken the
// earlier beat keeps the block in its final state; the next item is accepted after.
// Reset (aresetn low, synchronous) returns the sequencer to idle, restores the
// register defaults and drops m_tvalid; the point store keeps no reset value.
`default_nettype none
module bspline_de_boor_evaluator #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 7
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_index[5:0], in_x[37:6], in_y[69:38], in_z[101:70], param_u[125:102], zero pad
    input  wire logic [127:0] s_tdata,
    // func[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic      [95:0]  m_tdata,
    // status[0]
    output logic      [0:0]   m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [6:0]   cfg_wdata
);
    import bdb_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int PW   = $clog2(MAX_DEGREE + 1);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int NW   = $clog2(MAX_POINTS + MAX_DEGREE + 2);
    localparam int KW   = $clog2(MAX_POINTS + 2 * MAX_DEGREE + 3);
    localparam int LW   = $clog2(MAX_DEGREE + 2);
    localparam int CW   = (KW + FRAC_W > U_W) ? KW + FRAC_W : U_W;
    localparam int WW   = CW + 1;
    localparam int PTW  = 3 * COORD_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_SPAN = 12'b000000000010,
        S_LOAD = 12'b000000000100,
        S_RD0  = 12'b000000001000,
        S_RD1  = 12'b000000010000,
        S_CALC = 12'b000000100000,
        S_GO   = 12'b000001000000,
        S_WAIT = 12'b000010000000,
        S_WR   = 12'b000100000000,
        S_FR   = 12'b001000000000,
        S_FL   = 12'b010000000000,
        S_FIN  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  degree_reg;
    logic [6:0]  point_count_reg;
    logic        clamp_start_reg, clamp_end_reg, closed_curve_reg;

    logic [PW-1:0]   p_reg, r_reg, j_reg, ld_idx_reg;
    logic [CNTW-1:0] pts_reg;
    logic [NW-1:0]   n_reg, off_reg;
    logic [U_W-1:0]  u_reg;
    logic [LW-1:0]   ld_cnt_reg;
    logic            ld_v_reg;
    logic [1:0]      cc_reg;
    logic [PTW-1:0]  p0_reg, p1_reg, res_reg, fin_reg;
    logic            fin_status_reg;
    logic signed [WW-1:0] wa_reg, wb_reg;
    logic [PW-1:0]   d_reg;
    logic            m_tvalid_reg;
    logic [PTW-1:0]  m_tdata_reg;
    logic            m_tuser_reg;

    // Input fields.
    logic            in_func;
    logic [5:0]      in_index;
    logic [U_W-1:0]  in_u;
    logic [PTW-1:0]  in_point;
    logic            s_fire;

    assign in_func  = s_tuser[0];
    assign in_index = s_tdata[5:0];
    assign in_point = s_tdata[101:6];
    assign in_u     = s_tdata[125:102];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Effective degree and point count.
    logic [PW-1:0]   p_eff;
    logic [CNTW-1:0] pts_eff;
    logic [NW-1:0]   n_eff;
    logic [NW-1:0]   k_cur;

    always_comb begin
        p_eff   = (32'(degree_reg) > MAX_DEGREE) ? PW'(MAX_DEGREE) : PW'(degree_reg);
        pts_eff = (32'(point_count_reg) > MAX_POINTS) ? CNTW'(MAX_POINTS)
                                                      : CNTW'(point_count_reg);
        n_eff   = closed_curve_reg ? NW'(pts_eff) + NW'(p_eff) + 1'b1 : NW'(pts_eff);
        k_cur   = NW'(p_reg) + 1'b1;
    end

    function automatic logic [KW-1:0] knot_f(input logic [KW-1:0] idx);
        logic [KW-1:0] v;
        v = idx;
        if (clamp_start_reg && v < KW'(p_reg)) v = KW'(p_reg);
        if (clamp_end_reg && v > KW'(n_reg)) v = KW'(n_reg);
        return v + 1'b1;
    endfunction

    // Span search.
    logic [KW-1:0] span_knot;
    logic          span_more;

    always_comb begin
        span_knot = knot_f(KW'(k_cur) + KW'(off_reg));
        span_more = (off_reg < n_reg - k_cur) &&
                    (CW'(u_reg) > CW'({span_knot, FRAC_W'(0)}));
    end

    // Knots and weights for the current blend step.
    logic [KW-1:0]        kn_a, kn_b;
    logic signed [WW-1:0] wa_n, wb_n;

    always_comb begin
        kn_a = knot_f(KW'(off_reg) + KW'(k_cur) + KW'(j_reg));
        kn_b = knot_f(KW'(off_reg) + KW'(j_reg) + KW'(r_reg) + 1'b1);
        wa_n = WW'({kn_a, FRAC_W'(0)}) - WW'(u_reg);
        wb_n = WW'(u_reg) - WW'({kn_b, FRAC_W'(0)});
    end

    // Point store address for the gather of the active points.
    logic [NW-1:0] ld_c;
    logic [AW-1:0] store_raddr;

    always_comb begin
        ld_c = off_reg + NW'(ld_cnt_reg);
        if (ld_c >= NW'(pts_reg)) ld_c = ld_c - NW'(pts_reg);
        if (32'(ld_c) >= MAX_POINTS) ld_c = '0;
        store_raddr = AW'(ld_c);
    end

    logic            store_we;
    logic [AW-1:0]   store_waddr;
    logic [PTW-1:0]  store_rdata;

    assign store_we    = s_fire && (in_func == FUNC_LOAD) && (32'(in_index) < MAX_POINTS);
    assign store_waddr = AW'(in_index);

    bdb_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_store (
        .clk   (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (in_point),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Scratch row of the triangular scheme.
    logic            work_we;
    logic [PW-1:0]   work_waddr, work_raddr;
    logic [PTW-1:0]  work_wdata, work_rdata;

    always_comb begin
        work_we    = (state_reg == S_WR) || ((state_reg == S_LOAD) && ld_v_reg);
        work_waddr = (state_reg == S_WR) ? j_reg : ld_idx_reg;
        work_wdata = (state_reg == S_WR) ? res_reg : store_rdata;
        unique case (state_reg)
            S_RD1:   work_raddr = j_reg + 1'b1;
            S_FR:    work_raddr = '0;
            default: work_raddr = j_reg;
        endcase
    end

    bdb_ram #(.WIDTH(PTW), .DEPTH(MAX_DEGREE + 1)) u_work (
        .clk   (aclk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    // Shared blend unit, one coordinate at a time.
    logic               bl_start, bl_done;
    logic signed [31:0] bl_p0, bl_p1;
    logic        [31:0] bl_result;

    always_comb begin
        bl_start = (state_reg == S_GO);
        unique case (cc_reg)
            2'd0:    begin bl_p0 = p0_reg[31:0];  bl_p1 = p1_reg[31:0];  end
            2'd1:    begin bl_p0 = p0_reg[63:32]; bl_p1 = p1_reg[63:32]; end
            default: begin bl_p0 = p0_reg[95:64]; bl_p1 = p1_reg[95:64]; end
        endcase
    end

    bdb_blend #(.WW(WW), .DW(PW)) u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bl_start),
        .p0      (bl_p0),
        .p1      (bl_p1),
        .wa      (wa_reg),
        .wb      (wb_reg),
        .d       (d_reg),
        .done    (bl_done),
        .result  (bl_result)
    );

    logic row_more, rows_more, out_free;

    always_comb begin
        row_more  = ({1'b0, j_reg} + 1'b1) < ({1'b0, p_reg} - {1'b0, r_reg});
        rows_more = ({1'b0, r_reg} + 1'b1) < {1'b0, p_reg};
        out_free  = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && in_func == FUNC_EVAL) begin
                    state_next = (CNTW'(p_eff) >= pts_eff) ? S_FIN : S_SPAN;
                end
            end
            S_SPAN: if (!span_more) state_next = S_LOAD;
            S_LOAD: begin
                if (LW'(ld_cnt_reg) > LW'(p_reg)) begin
                    state_next = (p_reg == '0) ? S_FR : S_RD0;
                end
            end
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_CALC;
            S_CALC: state_next = S_GO;
            S_GO:   state_next = S_WAIT;
            S_WAIT: if (bl_done) state_next = (cc_reg == 2'd2) ? S_WR : S_GO;
            S_WR:   state_next = (row_more || rows_more) ? S_RD0 : S_FR;
            S_FR:   state_next = S_FL;
            S_FL:   state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            degree_reg       <= 3'd3;
            point_count_reg  <= '0;
            clamp_start_reg  <= 1'b0;
            clamp_end_reg    <= 1'b0;
            closed_curve_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            ld_v_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_DEGREE:       degree_reg       <= cfg_wdata[2:0];
                    REG_POINT_COUNT:  point_count_reg  <= cfg_wdata;
                    REG_CLAMP_START:  clamp_start_reg  <= cfg_wdata[0];
                    REG_CLAMP_END:    clamp_end_reg    <= cfg_wdata[0];
                    REG_CLOSED_CURVE: closed_curve_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            ld_v_reg <= (state_reg == S_LOAD) && (LW'(ld_cnt_reg) <= LW'(p_reg));
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                p_reg          <= p_eff;
                pts_reg        <= pts_eff;
                n_reg          <= n_eff;
                u_reg          <= in_u;
                off_reg        <= '0;
                ld_cnt_reg     <= '0;
                r_reg          <= '0;
                j_reg          <= '0;
                fin_reg        <= '0;
                fin_status_reg <= STATUS_ERR;
            end
            S_SPAN: if (span_more) off_reg <= off_reg + 1'b1;
            S_LOAD: begin
                ld_idx_reg <= PW'(ld_cnt_reg);
                if (LW'(ld_cnt_reg) <= LW'(p_reg)) ld_cnt_reg <= ld_cnt_reg + 1'b1;
            end
            S_RD1: begin
                p0_reg <= work_rdata;
                wa_reg <= wa_n;
                wb_reg <= wb_n;
                d_reg  <= PW'(kn_a - kn_b);
                cc_reg <= '0;
            end
            S_CALC: p1_reg <= work_rdata;
            S_WAIT: begin
                if (bl_done) begin
                    unique case (cc_reg)
                        2'd0:    res_reg[31:0]  <= bl_result;
                        2'd1:    res_reg[63:32] <= bl_result;
                        default: res_reg[95:64] <= bl_result;
                    endcase
                    cc_reg <= cc_reg + 1'b1;
                end
            end
            S_WR: begin
                if (row_more) begin
                    j_reg <= j_reg + 1'b1;
                end else begin
                    j_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
            end
            S_FL: begin
                fin_reg        <= work_rdata;
                fin_status_reg <= STATUS_OK;
            end
            S_FIN: begin
                if (out_free) begin
                    m_tdata_reg <= fin_reg;
                    m_tuser_reg <= fin_status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTHESIS
    // The blend unit answers only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        bl_done |-> state_reg == S_WAIT)
        else $error("blend result arrived outside the wait state");

    // The span search never runs past the last span.
    a_span_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SPAN |-> off_reg <= n_reg - k_cur)
        else $error("span offset beyond last span");

    // Scratch writes stay within the active points of the current degree.
    a_work_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        work_we |-> work_waddr <= p_reg)
        else $error("scratch write beyond degree");
`endif
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the B-spline de Boor curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bdb_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          SETTLE_CYCLES  = 40;
    localparam logic [2:0]  REG_UNUSED     = 3'd7;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        status;
    } curve_pt_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [6:0]   cfg_wdata = '0;

    bspline_de_boor_evaluator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Predictor copy of the block's registers and point store.
    int unsigned  cur_degree = 3;
    int unsigned  cur_count = 0;
    bit           cur_clamp_start = 0;
    bit           cur_clamp_end = 0;
    bit           cur_closed = 0;
    logic [31:0]  pts_x [64];
    logic [31:0]  pts_y [64];
    logic [31:0]  pts_z [64];

    curve_pt_t    pending_points [$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           rx_wait = 0;
    bit           calm = 0;

    function automatic longint knot_val(int i, int p, int n);
        int v;
        v = i;
        if (cur_clamp_start && v < p) v = p;
        if (cur_clamp_end && v > n) v = n;
        return longint'(v) + 1;
    endfunction

    function automatic longint blend_q16(longint p0, longint p1, longint wa, longint wb,
                                         longint den);
        longint num;
        longint unsigned mag, q;
        bit neg;
        num = wa * p0 + wb * p1;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag + den / 2) / den;
        if (!neg) return (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -longint'(q);
    endfunction

    function automatic curve_pt_t eval_curve(logic [23:0] u_q);
        curve_pt_t res;
        longint wx [8], wy [8], wz [8];
        longint u, a, b, wa, wb, den;
        int p, k, n, off, c;
        p = cur_degree;
        res = '0;
        if (p >= ((cur_count > 64) ? 64 : cur_count)) begin
            res.status = STATUS_ERR;
            return res;
        end
        k = p + 1;
        n = cur_closed ? cur_count + k : cur_count;
        if (cur_count > 64) n = cur_closed ? 64 + k : 64;
        u = longint'(u_q);
        off = 0;
        while (off < n - k && u > knot_val(k + off, p, n) * 65536) off++;
        for (int i = 0; i < k; i++) begin
            c = off + i;
            if (c >= ((cur_count > 64) ? 64 : cur_count)) c -= (cur_count > 64) ? 64 : cur_count;
            if (c >= 64) c = 0;
            wx[i] = longint'(signed'(pts_x[c]));
            wy[i] = longint'(signed'(pts_y[c]));
            wz[i] = longint'(signed'(pts_z[c]));
        end
        for (int r = 0; r < p; r++) begin
            for (int j = 0; j + 1 + r < k; j++) begin
                a = knot_val(off + k + j, p, n);
                b = knot_val(off + 1 + j + r, p, n);
                wa = a * 65536 - u;
                wb = u - b * 65536;
                den = (a - b) * 65536;
                wx[j] = blend_q16(wx[j], wx[j + 1], wa, wb, den);
                wy[j] = blend_q16(wy[j], wy[j + 1], wa, wb, den);
                wz[j] = blend_q16(wz[j], wz[j + 1], wa, wb, den);
            end
        end
        res.x = wx[0][31:0];
        res.y = wy[0][31:0];
        res.z = wz[0][31:0];
        res.status = STATUS_OK;
        return res;
    endfunction

    // Result checker, receiver stalls and the watchdog share the clock edge.
    always @(posedge aclk) begin
        curve_pt_t want;
        if (m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[31:0] !== want.x || m_tdata[63:32] !== want.y ||
                    m_tdata[95:64] !== want.z || m_tuser[0] !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h st=%b, got x=%h y=%h z=%h st=%b",
                                 want.x, want.y, want.z, want.status, m_tdata[31:0],
                                 m_tdata[63:32], m_tdata[95:64], m_tuser[0]);
                end
            end
            rx_wait = calm ? 0 : $urandom_range(0, 11);
            m_tready <= (rx_wait == 0);
        end else if (!m_tready) begin
            if (rx_wait > 0) rx_wait--;
            m_tready <= (rx_wait == 0);
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_wr_en || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_DEGREE:       cur_degree = 32'(val[2:0]);
            REG_POINT_COUNT:  cur_count = 32'(val);
            REG_CLAMP_START:  cur_clamp_start = val[0];
            REG_CLAMP_END:    cur_clamp_end = val[0];
            REG_CLOSED_CURVE: cur_closed = val[0];
            default: ;
        endcase
    endtask

    task automatic set_curve(int deg, int cnt, bit cs, bit ce, bit cl);
        write_reg(REG_DEGREE, 7'(deg));
        write_reg(REG_POINT_COUNT, 7'(cnt));
        write_reg(REG_CLAMP_START, {6'd0, cs});
        write_reg(REG_CLAMP_END, {6'd0, ce});
        write_reg(REG_CLOSED_CURVE, {6'd0, cl});
    endtask

    // Drives one beat; valid stays high into the next call when there is no gap.
    task automatic send_item(logic func, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [23:0] u);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, u, z, y, x, idx};
        do @(posedge aclk); while (!s_tready);
        if (func == FUNC_LOAD) begin
            pts_x[idx] = x;
            pts_y[idx] = y;
            pts_z[idx] = z;
        end else begin
            pending_points = {pending_points, eval_curve(u)};
        end
    endtask

    task automatic eval_at(logic [23:0] u);
        send_item(FUNC_EVAL, 6'($urandom), $urandom, $urandom, $urandom, u);
    endtask

    // Waits for every expected result, then lets a trailing load settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    task automatic test_fill_store;
        calm = 1;
        send_item(FUNC_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 24'hFFFFFF);
        send_item(FUNC_LOAD, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h0);
        for (int i = 2; i < 64; i++)
            send_item(FUNC_LOAD, 6'(i), rand_coord(), rand_coord(), rand_coord(),
                      24'($urandom));
        calm = 0;
        drain();
    endtask

    task automatic test_directed;
        eval_at(24'h01_0000);                  // no points: degree error
        drain();
        set_curve(4, 4, 0, 0, 0);
        eval_at(24'h02_8000);                  // degree equal to count
        drain();
        set_curve(0, 5, 0, 0, 0);
        eval_at(24'h03_0000);                  // degree zero
        eval_at(24'h00_0000);
        drain();
        set_curve(3, 8, 1, 1, 0);
        eval_at(24'h00_0000);                  // below the first span
        eval_at(24'h04_0000);                  // exactly on a knot
        eval_at(24'h05_8001);
        eval_at(24'hFF_FFFF);                  // far beyond the last span
        drain();
        set_curve(7, 127, 0, 1, 1);            // count above capacity, closed
        eval_at(24'h20_0000);
        eval_at(24'h47_8000);
        drain();
        set_curve(1, 2, 1, 0, 1);
        eval_at(24'h02_4000);
        eval_at(24'h00_C000);
        drain();
        write_reg(REG_UNUSED, 7'h7F);
    endtask

    task automatic test_random;
        int deg, cnt, span_hi;
        for (int ph = 0; ph < 16; ph++) begin
            deg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 20);
            set_curve(deg, cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            calm = ($urandom_range(0, 3) == 0);
            span_hi = (((cnt > 64) ? 64 : cnt) + 10) * 65536;
            for (int i = 0; i < 115; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(FUNC_LOAD, 6'($urandom), rand_coord(), rand_coord(),
                              rand_coord(), 24'($urandom));
                else if ($urandom_range(0, 4) == 0)
                    eval_at(24'($urandom));
                else
                    eval_at(24'($urandom_range(0, span_hi)));
            end
            drain();
        end
        calm = 0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_fill_store();
        test_directed();
        test_random();
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/bdb_pkg.sv
rtl/bdb_ram.sv
rtl/bdb_blend.sv
rtl/bspline_de_boor_evaluator.sv
bench/tb_top.sv
